// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the tlv walker checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/dtw_pkg.sv
// ----------------------------------------------------------------------------
// dtw_pkg
// types, codes and constants of the der tlv element walker
// ----------------------------------------------------------------------------
package dtw_pkg;

	localparam int DEFAULT_MAX_LENGTH_BYTES = 4;

	// walk phase codes
	localparam logic [1:0] PH_TAG       = 2'd0;
	localparam logic [1:0] PH_LEN_FIRST = 2'd1;
	localparam logic [1:0] PH_LEN_MORE  = 2'd2;
	localparam logic [1:0] PH_CONTENT   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_OUT_OF_DATA  = 2'd1;
	localparam logic [1:0] ST_LENGTH_ERROR = 2'd2;

	localparam logic [31:0] ACC_SHIFT_LIMIT = 32'h00FF_FFFF;
	localparam logic [2:0]  HDR_BYTES_MAX   = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} in_t;

	typedef struct packed {
		logic [7:0]  element_tag;
		logic [31:0] content_length;
		logic [2:0]  header_bytes;
		logic [31:0] element_offset;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [31:0] position;
		logic [31:0] element_start;
		logic [7:0]  held_tag;
		logic [31:0] length_acc;
		logic [2:0]  length_left;
		logic [31:0] content_left;
		logic        halted;
	} walk_t;

endpackage

// File: rtl/dtw_step.sv
// ----------------------------------------------------------------------------
// dtw_step
// next-state and result logic for one byte of the walk
// ----------------------------------------------------------------------------
module dtw_step #(
	parameter int MAX_LENGTH_BYTES = dtw_pkg::DEFAULT_MAX_LENGTH_BYTES,
	parameter int HDR_W = 3
) (
	input  dtw_pkg::walk_t   cur,
	input  logic [HDR_W-1:0] hdr_cnt,
	input  dtw_pkg::in_t     req,
	input  logic [31:0]      buffer_length,
	output dtw_pkg::walk_t   nxt,
	output logic [HDR_W-1:0] hdr_nxt,
	output logic             has_res,
	output dtw_pkg::out_t    res
);
	import dtw_pkg::*;

	walk_t       st;
	logic [32:0] diff;
	logic [31:0] bytes_after;
	logic [31:0] acc_new;
	logic [6:0]  len_cnt;
	logic [HDR_W-1:0] hb_wide;
	logic [2:0]  hb;
	logic [31:0] clen;
	logic [1:0]  status;
	logic        done_hdr;

	always_comb begin
		st = cur;
		if (req.start_req) begin
			st.position     = '0;
			st.phase        = PH_TAG;
			st.halted       = 1'b0;
			st.length_acc   = '0;
			st.length_left  = '0;
			st.content_left = '0;
		end

		// bytes still in the buffer after the current one, floored at zero
		diff        = {1'b0, buffer_length} - {1'b0, st.position} - 33'd1;
		bytes_after = diff[32] ? 32'd0 : diff[31:0];

		len_cnt  = req.data_byte[6:0];
		acc_new  = '0;
		hb_wide  = '0;
		hb       = '0;
		clen     = '0;
		status   = ST_OK;
		has_res  = 1'b0;
		done_hdr = 1'b0;
		nxt      = st;
		hdr_nxt  = hdr_cnt;
		nxt.position = st.position + 32'd1;

		if (!st.halted) begin
			unique case (st.phase)
				PH_TAG: begin
					nxt.held_tag      = req.data_byte;
					nxt.element_start = st.position;
					nxt.length_acc    = '0;
					if (bytes_after == 32'd0) begin
						has_res    = 1'b1;
						hb         = 3'd1;
						status     = ST_OUT_OF_DATA;
						nxt.halted = 1'b1;
						nxt.phase  = PH_TAG;
					end else begin
						nxt.phase = PH_LEN_FIRST;
					end
				end
				PH_LEN_FIRST: begin
					if (!req.data_byte[7]) begin
						// short form
						acc_new  = {24'd0, req.data_byte};
						hb       = 3'd2;
						done_hdr = 1'b1;
					end else if (len_cnt == 7'd0 || len_cnt > 7'(MAX_LENGTH_BYTES)) begin
						has_res    = 1'b1;
						hb         = 3'd2;
						status     = ST_LENGTH_ERROR;
						nxt.halted = 1'b1;
						nxt.phase  = PH_TAG;
					end else if (bytes_after < {25'd0, len_cnt}) begin
						has_res    = 1'b1;
						hb         = 3'd2;
						status     = ST_OUT_OF_DATA;
						nxt.halted = 1'b1;
						nxt.phase  = PH_TAG;
					end else begin
						nxt.length_acc  = '0;
						nxt.length_left = 3'(len_cnt - 7'd1);
						nxt.phase       = PH_LEN_MORE;
						hdr_nxt         = HDR_W'(2);
					end
				end
				PH_LEN_MORE: begin
					// saturate once another shift would overflow
					if (st.length_acc > ACC_SHIFT_LIMIT)
						acc_new = '1;
					else
						acc_new = {st.length_acc[23:0], req.data_byte};
					nxt.length_acc = acc_new;
					if (st.length_left == 3'd0) begin
						hb_wide  = hdr_cnt + HDR_W'(1);
						hb       = (hb_wide > HDR_W'(HDR_BYTES_MAX)) ? HDR_BYTES_MAX
							: hb_wide[2:0];
						done_hdr = 1'b1;
					end else begin
						nxt.length_left = st.length_left - 3'd1;
						hdr_nxt         = hdr_cnt + HDR_W'(1);
					end
				end
				PH_CONTENT: begin
					if (st.content_left != 32'd0)
						nxt.content_left = st.content_left - 32'd1;
					if (st.content_left <= 32'd1)
						nxt.phase = PH_TAG;
				end
				default: nxt.phase = PH_TAG;
			endcase

			if (done_hdr) begin
				has_res        = 1'b1;
				nxt.length_acc = acc_new;
				if (acc_new > bytes_after) begin
					status     = ST_OUT_OF_DATA;
					nxt.halted = 1'b1;
					nxt.phase  = PH_TAG;
				end else begin
					clen             = acc_new;
					nxt.content_left = acc_new;
					nxt.phase        = (acc_new != 32'd0) ? PH_CONTENT : PH_TAG;
				end
			end
		end

		res.element_tag    = nxt.held_tag;
		res.content_length = clen;
		res.header_bytes   = hb;
		res.element_offset = nxt.element_start;
		res.status         = status;
	end

endmodule

// File: rtl/der_tlv_element_walker.sv
// ----------------------------------------------------------------------------
// der_tlv_element_walker
// walks a der byte stream and reports one header record per tlv element
// ----------------------------------------------------------------------------
// an accepted byte waits in the input register; its record is registered in
// the result register as the byte moves on. throughput: one byte per cycle
// while no stalled record holds the input, set by the single registered state
// update. bytes that close no header give no record; at most one record per byte
// reset clears the walk state, buffer length, pipeline and output valid
module der_tlv_element_walker #(
	parameter int MAX_LENGTH_BYTES = dtw_pkg::DEFAULT_MAX_LENGTH_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	// byte requests in
	input  logic          byte_valid,
	output logic          byte_stall,
	input  dtw_pkg::in_t  byte_req,
	// element records out
	output logic          elem_valid,
	input  logic          elem_stall,
	output dtw_pkg::out_t elem_res,
	// buffer length register write
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [31:0]   cfg_data
);
	import dtw_pkg::*;

	// header byte counter wide enough for tag, first length byte and all long bytes
	localparam int HDR_NEED = $clog2(MAX_LENGTH_BYTES + 3);
	localparam int HDR_W    = (HDR_NEED > 3) ? HDR_NEED : 3;

	// input register stage
	logic  s1_valid_s1;
	in_t   s1_req_s1;

	// walk state
	walk_t            walk_q;
	logic [HDR_W-1:0] hdr_cnt_q;
	logic [31:0]      buffer_length_q;

	// result register
	logic  res_valid_q;
	out_t  res_q;

	// step outputs
	walk_t            walk_nxt;
	logic [HDR_W-1:0] hdr_nxt;
	logic             step_has_res;
	out_t             step_res;

	logic advance;

	// the s1 request moves on when the result register is free or drains now
	assign advance    = !res_valid_q || !elem_stall;
	assign byte_stall = s1_valid_s1 && !advance;
	assign elem_valid = res_valid_q;
	assign elem_res   = res_q;
	assign cfg_ready  = 1'b1;

	dtw_step #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
		.HDR_W(HDR_W)
	) u_step (
		.cur(walk_q),
		.hdr_cnt(hdr_cnt_q),
		.req(s1_req_s1),
		.buffer_length(buffer_length_q),
		.nxt(walk_nxt),
		.hdr_nxt(hdr_nxt),
		.has_res(step_has_res),
		.res(step_res)
	);

	// buffer length register; user must only write it between walks, not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			buffer_length_q <= cfg_data;
		end
	end

	// input stage: loads whenever it is not held by a stalled result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			s1_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			s1_req_s1 <= byte_req;
		end
	end

	// walk state update, one byte per cycle while the input stage advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q.phase         <= PH_TAG;
			walk_q.position      <= '0;
			walk_q.element_start <= '0;
			walk_q.held_tag      <= '0;
			walk_q.length_acc    <= '0;
			walk_q.length_left   <= '0;
			walk_q.content_left  <= '0;
			walk_q.halted        <= 1'b0;
			hdr_cnt_q            <= '0;
		end else if (s1_valid_s1 && advance) begin
			walk_q    <= walk_nxt;
			hdr_cnt_q <= hdr_nxt;
		end
	end

	// result register: holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= s1_valid_s1 && step_has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_s1 && step_has_res) begin
			res_q <= step_res;
		end
	end

endmodule

// File: rtl/dtw_checker.sv
// ----------------------------------------------------------------------------
// dtw_checker
// port-level checks of the tlv walker, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtw_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          byte_stall,
	input logic          elem_valid,
	input logic          elem_stall,
	input dtw_pkg::out_t elem_res
);
	import dtw_pkg::*;

	// a stalled record stays put
	`ASSERT_NEXT(a_res_hold, clk, arst_n, elem_valid && elem_stall, elem_valid && $stable(elem_res))
	// every record counts at least the tag byte
	`ASSERT_IMPLIES(a_hdr_nonzero, clk, arst_n, elem_valid, elem_res.header_bytes != 3'd0)
	// an error record carries no length
	`ASSERT_IMPLIES(a_err_no_len, clk, arst_n, elem_valid && elem_res.status != ST_OK, elem_res.content_length == 32'd0)
	// a good header has at least a tag and one length byte
	`ASSERT_IMPLIES(a_ok_hdr_min, clk, arst_n, elem_valid && elem_res.status == ST_OK, elem_res.header_bytes >= 3'd2)
	// the input only stalls behind a stalled record
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, byte_stall, elem_valid && elem_stall)

endmodule

bind der_tlv_element_walker dtw_checker u_dtw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.byte_stall(byte_stall),
	.elem_valid(elem_valid),
	.elem_stall(elem_stall),
	.elem_res(elem_res)
);

// File: verif/der_tlv_element_walker_test.sv
// ----------------------------------------------------------------------------
// der_tlv_element_walker_test
// self-checking bench for the der tlv element walker: a directed table of
// header edge cases, then randomly built tlv buffers with noise and broken
// lengths; typed table rows are scored against their own records, all
// other records against a cycle-free model of the walk
module der_tlv_element_walker_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtw_pkg::*;

	// settle time before touching the register and at the end of the run
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int RANDOM_ITEMS    = 1950;
	localparam int MAX_LEN_BYTES   = DEFAULT_MAX_LENGTH_BYTES;

	// kinds of rows in the directed table
	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_BYTE,
		ROW_TYPED
	} row_kind_e;

	// receiver stall patterns
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [31:0] cfg_value;
		in_t         req;
		out_t        rec;
	} dir_row_t;

	// directed rows: typed records only where the answer is plain from the spec
	localparam dir_row_t DIRECTED [30] = '{
		// buffer length still zero after reset: first tag is already past the end
		'{ROW_TYPED, 32'd0, '{8'hFF, 1'b1}, '{8'hFF, 32'd0, 3'd1, 32'd0, ST_OUT_OF_DATA}},
		// halted: ignored until the next start
		'{ROW_BYTE,  32'd0, '{8'h00, 1'b0}, '0},
		'{ROW_CFG,   32'hFFFF_FFFF, '0, '0},
		// four length bytes of all ones, longer than anything left
		'{ROW_BYTE,  32'd0, '{8'h30, 1'b1}, '0},
		'{ROW_BYTE,  32'd0, '{8'h84, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'hFF, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'hFF, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'hFF, 1'b0}, '0},
		'{ROW_TYPED, 32'd0, '{8'hFF, 1'b0}, '{8'h30, 32'd0, 3'd6, 32'd0, ST_OUT_OF_DATA}},
		// too many length bytes
		'{ROW_BYTE,  32'd0, '{8'h00, 1'b1}, '0},
		'{ROW_TYPED, 32'd0, '{8'h85, 1'b0}, '{8'h00, 32'd0, 3'd2, 32'd0, ST_LENGTH_ERROR}},
		// indefinite length marker
		'{ROW_BYTE,  32'd0, '{8'h02, 1'b1}, '0},
		'{ROW_TYPED, 32'd0, '{8'h80, 1'b0}, '{8'h02, 32'd0, 3'd2, 32'd0, ST_LENGTH_ERROR}},
		// empty element, one-byte long form, largest short form
		'{ROW_BYTE,  32'd0, '{8'h04, 1'b1}, '0},
		'{ROW_BYTE,  32'd0, '{8'h00, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'hA5, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'h81, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'h01, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'h5A, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'h7F, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'h7F, 1'b0}, '0},
		'{ROW_CFG,   32'd3, '0, '0},
		// long form length bytes would run past the end
		'{ROW_BYTE,  32'd0, '{8'h10, 1'b1}, '0},
		'{ROW_TYPED, 32'd0, '{8'h82, 1'b0}, '{8'h10, 32'd0, 3'd2, 32'd0, ST_OUT_OF_DATA}},
		// walk ends exactly at the end, then one more tag
		'{ROW_BYTE,  32'd0, '{8'h11, 1'b1}, '0},
		'{ROW_BYTE,  32'd0, '{8'h01, 1'b0}, '0},
		'{ROW_BYTE,  32'd0, '{8'hEE, 1'b0}, '0},
		'{ROW_TYPED, 32'd0, '{8'h3C, 1'b0}, '{8'h3C, 32'd0, 3'd1, 32'd3, ST_OUT_OF_DATA}},
		'{ROW_CFG,   32'd1, '0, '0},
		// tag on the only byte: no room for a length
		'{ROW_TYPED, 32'd0, '{8'h1F, 1'b1}, '{8'h1F, 32'd0, 3'd1, 32'd0, ST_OUT_OF_DATA}}
	};

	logic  clk = 1'b0;
	logic  arst_n;
	logic  byte_valid;
	logic  byte_stall;
	in_t   byte_req;
	logic  elem_valid;
	logic  elem_stall;
	out_t  elem_res;
	logic  cfg_valid;
	logic  cfg_ready;
	logic [31:0] cfg_data;

	// walker model state, starts at the reset values
	logic [31:0] w_buf_len = '0;
	logic [1:0]  w_phase   = PH_TAG;
	logic [31:0] w_pos     = '0;
	logic [31:0] w_start   = '0;
	logic [7:0]  w_tag     = '0;
	logic [31:0] w_acc     = '0;
	logic [2:0]  w_left    = '0;
	logic [31:0] w_content = '0;
	logic        w_halted  = 1'b0;

	out_t        due_records [$];
	logic [7:0]  walk_bytes [$];
	int          fail_count    = 0;
	int          sent_bytes    = 0;
	int          burst_left    = 0;
	bit          hold_off_req  = 1'b0;

	der_tlv_element_walker DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.elem_res   (elem_res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// walker model
	// ------------------------------------------------------------------

	// buffer bytes after the current position, zero once at or past the end
	function automatic logic [31:0] room_after();
		logic [63:0] next_pos;
		next_pos = {32'd0, w_pos} + 64'd1;
		return (next_pos < {32'd0, w_buf_len}) ? 32'({32'd0, w_buf_len} - next_pos) : 32'd0;
	endfunction

	function automatic out_t element_record(input logic [31:0] clen, input int unsigned hb,
			input logic [1:0] st);
		out_t r;
		r.element_tag    = w_tag;
		r.content_length = clen;
		r.header_bytes   = (hb > HDR_BYTES_MAX) ? HDR_BYTES_MAX : 3'(hb);
		r.element_offset = w_start;
		r.status         = st;
		return r;
	endfunction

	// error record, then the walk halts until the next start
	function automatic out_t abort_walk(input int unsigned hb, input logic [1:0] st);
		w_halted = 1'b1;
		w_phase  = PH_TAG;
		return element_record(32'd0, hb, st);
	endfunction

	// header complete: content must fit in what is left of the buffer
	function automatic out_t close_header(input int unsigned hb);
		out_t r;
		if (w_acc > room_after())
			return abort_walk(hb, ST_OUT_OF_DATA);
		r = element_record(w_acc, hb, ST_OK);
		w_content = w_acc;
		w_phase = (w_content != 0) ? PH_CONTENT : PH_TAG;
		return r;
	endfunction

	// one accepted byte through the walk; at most one record comes out
	function automatic void walk_byte(input in_t req, output bit got, output out_t rec);
		logic [6:0] count;
		got = 1'b0;
		rec = '0;
		if (req.start_req) begin
			w_pos     = '0;
			w_phase   = PH_TAG;
			w_halted  = 1'b0;
			w_acc     = '0;
			w_left    = '0;
			w_content = '0;
		end
		if (!w_halted) begin
			case (w_phase)
				PH_TAG: begin
					w_tag   = req.data_byte;
					w_start = w_pos;
					w_acc   = '0;
					if (w_pos >= w_buf_len || room_after() == 0) begin
						rec = abort_walk(1, ST_OUT_OF_DATA);
						got = 1'b1;
					end else begin
						w_phase = PH_LEN_FIRST;
					end
				end
				PH_LEN_FIRST: begin
					if (!req.data_byte[7]) begin
						w_acc = {24'd0, req.data_byte};
						rec = close_header(2);
						got = 1'b1;
					end else begin
						count = req.data_byte[6:0];
						if (count == 0 || count > MAX_LEN_BYTES) begin
							rec = abort_walk(2, ST_LENGTH_ERROR);
							got = 1'b1;
						end else if (room_after() < count) begin
							rec = abort_walk(2, ST_OUT_OF_DATA);
							got = 1'b1;
						end else begin
							w_acc   = '0;
							w_left  = 3'(count - 1);
							w_phase = PH_LEN_MORE;
						end
					end
				end
				PH_LEN_MORE: begin
					w_acc = (w_acc > ACC_SHIFT_LIMIT) ? '1 : {w_acc[23:0], req.data_byte};
					if (w_left == 0) begin
						rec = close_header(w_pos - w_start + 1);
						got = 1'b1;
					end else begin
						w_left = w_left - 3'd1;
					end
				end
				default: begin
					if (w_content != 0)
						w_content = w_content - 1;
					if (w_content == 0)
						w_phase = PH_TAG;
				end
			endcase
		end
		w_pos = w_pos + 1;
	endfunction

	// ------------------------------------------------------------------
	// random buffer builder: tlv elements with random tags and content
	// ------------------------------------------------------------------
	function automatic void append_byte(input logic [7:0] b);
		walk_bytes.insert(walk_bytes.size(), b);
	endfunction

	function automatic void build_walk(input bit dense);
		int elems;
		int clen;
		int nlen;
		int pick;
		logic [31:0] lval;
		walk_bytes.delete();
		// plain noise now and then
		if (!dense && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 24))
				append_byte(8'($urandom));
			return;
		end
		elems = dense ? 30 : $urandom_range(1, 6);
		for (int e = 0; e < elems; e++) begin
			append_byte(8'($urandom));
			pick = dense ? 50 : $urandom_range(0, 99);
			// broken length field: indefinite, too many bytes, or a huge length
			if (pick < 4) begin
				case ($urandom_range(0, 2))
					0: append_byte(8'h80);
					1: append_byte(8'h80 | 8'($urandom_range(5, 127)));
					default: begin
						append_byte(8'h84);
						repeat (4)
							append_byte(8'($urandom));
					end
				endcase
				continue;
			end
			if (dense)
				clen = 0;
			else if (pick < 70)
				clen = $urandom_range(0, 12);
			else if (pick < 95)
				clen = $urandom_range(13, 200);
			else
				clen = $urandom_range(201, 700);
			lval = 32'(clen);
			if (clen < 128 && $urandom_range(0, 2) != 0) begin
				append_byte(lval[7:0]);
			end else begin
				// long form, sometimes padded with leading zero bytes
				nlen = (clen > 255) ? 2 : 1;
				nlen = nlen + $urandom_range(0, MAX_LEN_BYTES - nlen);
				append_byte(8'h80 | 8'(nlen));
				for (int k = nlen - 1; k >= 0; k--)
					append_byte(lval[8*k +: 8]);
			end
			repeat (clen)
				append_byte(8'($urandom));
		end
	endfunction

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// offer one byte request in bursts with random gaps, predict on acceptance
	task automatic send_byte(input in_t req, input bit typed, input out_t typed_rec);
		int gap;
		bit got;
		out_t rec;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		byte_req   <= req;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		walk_byte(req, got, rec);
		// typed rows carry their record from the table
		if (typed)
			due_records.insert(due_records.size(), typed_rec);
		else if (got)
			due_records.insert(due_records.size(), rec);
		sent_bytes++;
	endtask

	// register write only once the block has gone quiet
	task automatic set_buffer_length(input logic [31:0] len);
		byte_valid <= 1'b0;
		while (due_records.size() != 0)
			@(posedge clk);
		// a byte that closes no header may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		w_buf_len = len;
		burst_left = 0;
	endtask

	// ------------------------------------------------------------------
	// receiver side: stall patterns, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin : result_stall_pattern
		stall_mode_e stall_mode;
		int stall_span;
		elem_stall <= 1'b0;
		forever begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_span = $urandom_range(8, 60);
			while (stall_span > 0 && !hold_off_req) begin
				@(posedge clk);
				case (stall_mode)
					STALL_NONE:  elem_stall <= 1'b0;
					STALL_LIGHT: elem_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: elem_stall <= ($urandom_range(0, 3) != 0);
					default:     elem_stall <= ~elem_stall;
				endcase
				stall_span--;
			end
			// long hold-off: output backs up until the block stalls its input
			if (hold_off_req) begin
				@(posedge clk);
				elem_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// record checker: each accepted record against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : record_check
		out_t want;
		if (arst_n && elem_valid && !elem_stall) begin
			if (due_records.size() == 0) begin
				$error("unexpected element record, tag %0h offset %0d",
					elem_res.element_tag, elem_res.element_offset);
				fail_count++;
			end else begin
				want = due_records.pop_front();
				if (elem_res.element_tag !== want.element_tag) begin
					$error("element_tag expected %0h actual %0h",
						want.element_tag, elem_res.element_tag);
					fail_count++;
				end
				if (elem_res.content_length !== want.content_length) begin
					$error("content_length expected %0d actual %0d",
						want.content_length, elem_res.content_length);
					fail_count++;
				end
				if (elem_res.header_bytes !== want.header_bytes) begin
					$error("header_bytes expected %0d actual %0d",
						want.header_bytes, elem_res.header_bytes);
					fail_count++;
				end
				if (elem_res.element_offset !== want.element_offset) begin
					$error("element_offset expected %0d actual %0d",
						want.element_offset, elem_res.element_offset);
					fail_count++;
				end
				if (elem_res.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, elem_res.status);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		in_t req;
		int blen;
		int pick;
		int drain;
		bit with_start;
		bit dense;
		logic [31:0] new_len;
		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		byte_req   <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIRECTED[i]) begin
			case (DIRECTED[i].kind)
				ROW_CFG:   set_buffer_length(DIRECTED[i].cfg_value);
				ROW_TYPED: send_byte(DIRECTED[i].req, 1'b1, DIRECTED[i].rec);
				default:   send_byte(DIRECTED[i].req, 1'b0, '0);
			endcase
		end

		// random buffers; the first one is dense with records to back up the output
		sent_bytes = 0;
		dense = 1'b1;
		while (sent_bytes < RANDOM_ITEMS) begin
			build_walk(dense);
			blen = walk_bytes.size();
			pick = $urandom_range(0, 99);
			if (dense || pick < 60)
				new_len = 32'(blen);
			else if (pick < 70)
				new_len = 32'(blen + $urandom_range(1, 5));
			else if (pick < 85)
				new_len = 32'($urandom_range(0, blen));
			else if (pick < 90)
				new_len = 32'd0;
			else if (pick < 95)
				new_len = 32'hFFFF_FFFF;
			else
				new_len = $urandom;
			// now and then the length changes under a walk that carries on
			with_start = dense || ($urandom_range(0, 9) != 0);
			if (dense || $urandom_range(0, 9) != 0)
				set_buffer_length(new_len);
			if (dense)
				hold_off_req = 1'b1;
			foreach (walk_bytes[i]) begin
				if (sent_bytes >= RANDOM_ITEMS)
					break;
				req.data_byte = walk_bytes[i];
				req.start_req = (i == 0 && with_start) || ($urandom_range(0, 99) == 0);
				send_byte(req, 1'b0, '0);
			end
			// stray bytes after the buffer
			if (sent_bytes < RANDOM_ITEMS && $urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					req.data_byte = 8'($urandom);
					req.start_req = 1'b0;
					send_byte(req, 1'b0, '0);
				end
			end
			dense = 1'b0;
		end

		// drain what is still due, then let the pipe settle
		byte_valid <= 1'b0;
		drain = 0;
		while (due_records.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_records.size() != 0) begin
			$error("%0d element records never arrived", due_records.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin : watchdog
		#5ms;
		$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/dtw_pkg.sv
rtl/dtw_step.sv
rtl/der_tlv_element_walker.sv
rtl/dtw_checker.sv
verif/der_tlv_element_walker_test.sv
